@@ src/segment_intersection_top_assert.svh @@
// Assertion macros for the segment intersection block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef SEGMENT_INTERSECTION_TOP_ASSERT_SVH
`define SEGMENT_INTERSECTION_TOP_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define SGI_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define SGI_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ src/sgi_pkg.sv @@
// Shared types, widths and helpers for the segment intersection pipeline.
// No dependencies; imported by every module of the block.
package sgi_pkg;

  localparam int COORD_BITS      = 16;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int POINT_FRAC      = 8;
  localparam int TOL_BITS        = 16;
  localparam int OUT_BITS        = 32;

  localparam int DW       = COORD_BITS + 1;       // coordinate difference
  localparam int PW       = 2 * DW;               // difference product
  localparam int NW       = PW + 1;               // denominator / numerator
  localparam int MW       = PW;                   // magnitude of NW value
  localparam int QW       = OUT_BITS;             // quotient bits
  localparam int HI_SHIFT = QW - PARAM_FRAC_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] seg1_start_x;
    logic signed [COORD_BITS-1:0] seg1_start_y;
    logic signed [COORD_BITS-1:0] seg1_end_x;
    logic signed [COORD_BITS-1:0] seg1_end_y;
    logic signed [COORD_BITS-1:0] seg2_start_x;
    logic signed [COORD_BITS-1:0] seg2_start_y;
    logic signed [COORD_BITS-1:0] seg2_end_x;
    logic signed [COORD_BITS-1:0] seg2_end_y;
    logic                         require_on_seg1;
    logic                         require_on_seg2;
  } in_req_t;

  typedef struct packed {
    logic                       is_parallel;
    logic                       is_collinear;
    logic                       lines_cross;
    logic                       within_seg1;
    logic                       within_seg2;
    logic                       within_both;
    logic                       accepted;
    logic signed [OUT_BITS-1:0] cross_x;
    logic signed [OUT_BITS-1:0] cross_y;
    logic signed [OUT_BITS-1:0] seg1_param;
    logic signed [OUT_BITS-1:0] seg2_param;
  } out_req_t;

  typedef struct packed {
    logic                         par;
    logic                         col;
    logic                         on1;
    logic                         on2;
    logic                         req1;
    logic                         req2;
    logic                         neg1;
    logic                         neg2;
    logic                         ovf1;
    logic                         ovf2;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [DW-1:0]         dx1;
    logic signed [DW-1:0]         dy1;
  } meta_t;

  typedef struct packed {
    logic [MW-1:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] q;
  } lane_t;

  typedef struct packed {
    logic          vld;
    meta_t         meta;
    logic [MW-1:0] d;
    lane_t         l1;
    lane_t         l2;
  } div_t;

  function automatic logic [MW-1:0] absv(logic signed [NW-1:0] v);
    logic signed [NW-1:0] t;
    t = v[NW-1] ? -v : v;
    return t[MW-1:0];
  endfunction

endpackage

@@ src/sgi_front.sv @@
// Front end: differences, cross products, denominator and numerators,
// magnitudes, flags and divider seeds. Depends on sgi_pkg.
module sgi_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  sgi_pkg::in_req_t                 in_data,
  input  logic [sgi_pkg::TOL_BITS-1:0]     tol,
  output sgi_pkg::div_t                    dout
);
  import sgi_pkg::*;

  // stage 0: captured request
  logic    v0_r;
  in_req_t in_r;
  // stage 1: differences
  logic v1_r;
  logic signed [DW-1:0] dx1_r, dy1_r, dx2_r, dy2_r, ex_r, ey_r;
  logic signed [COORD_BITS-1:0] x1_r, y1_r, x1b_r, y1b_r, x1c_r, y1c_r;
  logic req1_r, req2_r, req1b_r, req2b_r, req1c_r, req2c_r;
  // stage 2: products
  logic v2_r;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;
  logic signed [DW-1:0] dx1b_r, dy1b_r, dx1c_r, dy1c_r;
  // stage 3: denominator and numerators
  logic v3_r;
  logic signed [NW-1:0] den_r, n1_r, n2_r;
  // stage 4
  div_t dout_r, dout_nxt;

  logic [MW-1:0] magd, magn1, magn2, tol_x;
  logic [MW+PARAM_FRAC_BITS-1:0] sh1, sh2;

  always_comb begin
    magd  = absv(den_r);
    magn1 = absv(n1_r);
    magn2 = absv(n2_r);
    tol_x = MW'(tol);
    sh1   = {magn1, {PARAM_FRAC_BITS{1'b0}}};
    sh2   = {magn2, {PARAM_FRAC_BITS{1'b0}}};
    dout_nxt.vld       = v3_r;
    dout_nxt.d         = magd;
    dout_nxt.meta.par  = magd <= tol_x;
    dout_nxt.meta.col  = magn1 <= tol_x;
    dout_nxt.meta.on1  = (n1_r == '0) || ((n1_r[NW-1] == den_r[NW-1]) && (magn1 <= magd));
    dout_nxt.meta.on2  = (n2_r == '0) || ((n2_r[NW-1] == den_r[NW-1]) && (magn2 <= magd));
    dout_nxt.meta.neg1 = n1_r[NW-1] ^ den_r[NW-1];
    dout_nxt.meta.neg2 = n2_r[NW-1] ^ den_r[NW-1];
    dout_nxt.meta.ovf1 = (magn1 >> HI_SHIFT) >= magd;
    dout_nxt.meta.ovf2 = (magn2 >> HI_SHIFT) >= magd;
    dout_nxt.meta.req1 = req1c_r;
    dout_nxt.meta.req2 = req2c_r;
    dout_nxt.meta.x1   = x1c_r;
    dout_nxt.meta.y1   = y1c_r;
    dout_nxt.meta.dx1  = dx1c_r;
    dout_nxt.meta.dy1  = dy1c_r;
    dout_nxt.l1.rem    = magn1 >> HI_SHIFT;
    dout_nxt.l1.low    = sh1[QW-1:0];
    dout_nxt.l1.q      = '0;
    dout_nxt.l2.rem    = magn2 >> HI_SHIFT;
    dout_nxt.l2.low    = sh2[QW-1:0];
    dout_nxt.l2.q      = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r       <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      dout_r.vld <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      in_r <= in_data;
      v1_r  <= v0_r;
      dx1_r <= DW'(in_r.seg1_end_x) - DW'(in_r.seg1_start_x);
      dy1_r <= DW'(in_r.seg1_end_y) - DW'(in_r.seg1_start_y);
      dx2_r <= DW'(in_r.seg2_end_x) - DW'(in_r.seg2_start_x);
      dy2_r <= DW'(in_r.seg2_end_y) - DW'(in_r.seg2_start_y);
      ex_r  <= DW'(in_r.seg1_start_x) - DW'(in_r.seg2_start_x);
      ey_r  <= DW'(in_r.seg1_start_y) - DW'(in_r.seg2_start_y);
      x1_r  <= in_r.seg1_start_x;
      y1_r  <= in_r.seg1_start_y;
      req1_r <= in_r.require_on_seg1;
      req2_r <= in_r.require_on_seg2;
      v2_r   <= v1_r;
      pa_r   <= PW'(dx1_r) * PW'(dy2_r);
      pb_r   <= PW'(dy1_r) * PW'(dx2_r);
      pc_r   <= PW'(ey_r) * PW'(dx2_r);
      pd_r   <= PW'(ex_r) * PW'(dy2_r);
      pe_r   <= PW'(ey_r) * PW'(dx1_r);
      pf_r   <= PW'(ex_r) * PW'(dy1_r);
      x1b_r  <= x1_r;
      y1b_r  <= y1_r;
      dx1b_r <= dx1_r;
      dy1b_r <= dy1_r;
      req1b_r <= req1_r;
      req2b_r <= req2_r;
      v3_r   <= v2_r;
      den_r  <= NW'(pa_r) - NW'(pb_r);
      n1_r   <= NW'(pc_r) - NW'(pd_r);
      n2_r   <= NW'(pe_r) - NW'(pf_r);
      x1c_r  <= x1b_r;
      y1c_r  <= y1b_r;
      dx1c_r <= dx1b_r;
      dy1c_r <= dy1b_r;
      req1c_r <= req1b_r;
      req2c_r <= req2b_r;
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

@@ src/sgi_div.sv @@
// Two-lane restoring divider, one quotient bit per register stage.
// Depends on sgi_pkg; carries the request metadata alongside.
module sgi_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  sgi_pkg::div_t  din,
  output sgi_pkg::div_t  dout
);
  import sgi_pkg::*;

  div_t st_r   [QW];
  div_t st_nxt [QW];

  function automatic lane_t div_step(lane_t l, logic [MW-1:0] d);
    lane_t        o;
    logic [MW:0]  sh;
    logic         bit_q;
    sh    = {l.rem, l.low[QW-1]};
    bit_q = sh >= {1'b0, d};
    if (bit_q) sh = sh - {1'b0, d};
    o.rem = sh[MW-1:0];
    o.low = {l.low[QW-2:0], 1'b0};
    o.q   = {l.q[QW-2:0], bit_q};
    return o;
  endfunction

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      st_nxt[k]    = (k == 0) ? din : st_r[(k == 0) ? 0 : k - 1];
      st_nxt[k].l1 = div_step(st_nxt[k].l1, st_nxt[k].d);
      st_nxt[k].l2 = div_step(st_nxt[k].l2, st_nxt[k].d);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) st_r[k].vld <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < QW; k++) st_r[k] <= st_nxt[k];
    end
  end

  assign dout = st_r[QW-1];

endmodule

@@ src/sgi_point.sv @@
// Back end: saturate quotients to parameters, scale deltas, form the
// crossing point and the output register. Depends on sgi_pkg.
module sgi_point (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  sgi_pkg::div_t     din,
  output logic              out_vld,
  output sgi_pkg::out_req_t out_data
);
  import sgi_pkg::*;

  localparam int PRW = OUT_BITS + DW;
  localparam int SW  = PRW + 1;
  localparam int PSH = PARAM_FRAC_BITS - POINT_FRAC;
  localparam logic signed [SW-1:0] POS_LIM = {{(SW-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] NEG_LIM = {{(SW-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}};

  function automatic logic signed [OUT_BITS-1:0] sat_q(logic [QW-1:0] q, logic ovf,
                                                      logic neg);
    logic [QW-1:0] cap, m;
    cap = neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    m   = (ovf || q > cap) ? cap : q;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [OUT_BITS-1:0] place(logic signed [COORD_BITS-1:0] base,
                                                      logic signed [PRW-1:0] p);
    logic [PRW-1:0]       pm;
    logic signed [SW-1:0] off, v;
    pm  = p[PRW-1] ? PRW'(-p) : PRW'(p);
    pm  = pm >> PSH;
    off = p[PRW-1] ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
    v   = (SW'(base) <<< POINT_FRAC) + off;
    if (v > POS_LIM) v = POS_LIM;
    if (v < NEG_LIM) v = NEG_LIM;
    return v[OUT_BITS-1:0];
  endfunction

  logic                         va_r, vb_r, out_vld_r;
  meta_t                        ma_r, mb_r;
  logic signed [OUT_BITS-1:0]   ra_r, sa_r, rb_r, sb_r;
  logic signed [PRW-1:0]        px_r, py_r;
  out_req_t                     out_r, out_nxt;

  always_comb begin
    out_nxt.is_parallel  = mb_r.par;
    out_nxt.is_collinear = mb_r.par && mb_r.col;
    out_nxt.lines_cross  = !mb_r.par;
    out_nxt.within_seg1  = !mb_r.par && mb_r.on1;
    out_nxt.within_seg2  = !mb_r.par && mb_r.on2;
    out_nxt.within_both  = !mb_r.par && mb_r.on1 && mb_r.on2;
    out_nxt.accepted     = !mb_r.par && (!mb_r.req1 || mb_r.on1) && (!mb_r.req2 || mb_r.on2);
    out_nxt.cross_x      = mb_r.par ? '0 : place(mb_r.x1, px_r);
    out_nxt.cross_y      = mb_r.par ? '0 : place(mb_r.y1, py_r);
    out_nxt.seg1_param   = rb_r;
    out_nxt.seg2_param   = sb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      va_r <= din.vld;
      ma_r <= din.meta;
      ra_r <= din.meta.par ? '0 : sat_q(din.l1.q, din.meta.ovf1, din.meta.neg1);
      sa_r <= din.meta.par ? '0 : sat_q(din.l2.q, din.meta.ovf2, din.meta.neg2);
      vb_r <= va_r;
      mb_r <= ma_r;
      rb_r <= ra_r;
      sb_r <= sa_r;
      px_r <= PRW'(ra_r) * PRW'(ma_r.dx1);
      py_r <= PRW'(ra_r) * PRW'(ma_r.dy1);
      out_vld_r <= vb_r;
      out_r     <= out_nxt;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_r;

endmodule

@@ src/segment_intersection_top.sv @@
// Top level of the segment intersection pipeline.
// Depends on sgi_pkg, sgi_front, sgi_div, sgi_point and the assert header.

// Segment intersection: each request carries two segments with signed
// endpoints; the block answers with exactly one result per request, in
// order. It accepts one request per cycle unless the output stalls, and
// each request passes 40 register stages: 5 front-end stages (input
// capture, differences, multiplies, denominator/numerator, magnitudes
// and flags), 32 divider stages that retire one quotient bit each for
// both parameters, and 3 back-end stages (saturate, point multiply,
// point add and output register). The whole pipeline advances together
// whenever the output register is empty or being drained, so a stalled
// result holds every stage and nothing is lost or repeated. The tolerance
// register is written through cfg_wr_en/cfg_wr_data, resets to 0, and must
// only be changed while the pipeline is empty.
module segment_intersection_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sgi_pkg::in_req_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sgi_pkg::out_req_t             out_data,
  input  logic                          cfg_wr_en,
  input  logic [sgi_pkg::TOL_BITS-1:0]  cfg_wr_data
);
  import sgi_pkg::*;

  `include "segment_intersection_top_assert.svh"

  logic [TOL_BITS-1:0] tol_r;
  logic                en;
  div_t                front_q, div_q;

  // advance every stage when the output register can take a request
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  sgi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .tol      (tol_r),
    .dout     (front_q)
  );

  sgi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .din   (front_q),
    .dout  (div_q)
  );

  sgi_point u_point (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .din      (div_q),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

  `SGI_ASSERT_SAME(a_par_no_cross, out_valid && out_data.is_parallel,
    !out_data.lines_cross && out_data.cross_x == 0 && out_data.seg1_param == 0,
    "parallel result carries crossing data")
  `SGI_ASSERT_SAME(a_acc_cross, out_valid && out_data.accepted, out_data.lines_cross,
    "accepted without a crossing")
  `SGI_ASSERT_SAME(a_col_par, out_valid && out_data.is_collinear, out_data.is_parallel,
    "collinear without parallel")
  `SGI_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_data),
    "stalled result changed")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for segment_intersection_top: random and directed
// segment pairs, predicted results compared field by field. Depends on sgi_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sgi_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_req_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [TOL_BITS-1:0] cfg_wr_data = '0;

  segment_intersection_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Requests waiting to be driven, and results predicted for accepted ones.
  in_req_t  pending_reqs[$];
  out_req_t expected_results[$];
  logic [TOL_BITS-1:0] tolerance = '0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit hold_sender = 1'b0;

  function automatic longint mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Magnitude of trunc(n * 2^16 / d), clamped to cap.
  function automatic longint frac_quotient(longint n, longint d, longint cap);
    longint q, rem, val;
    q = n / d;
    if (q > (cap >>> PARAM_FRAC_BITS)) return cap;
    rem = n - q * d;
    val = q <<< PARAM_FRAC_BITS;
    for (int i = PARAM_FRAC_BITS - 1; i >= 0; i--) begin
      rem = rem <<< 1;
      if (rem >= d) begin
        rem -= d;
        val |= longint'(1) <<< i;
      end
    end
    return val > cap ? cap : val;
  endfunction

  function automatic longint seg_param(longint num, longint den);
    bit neg;
    longint m;
    neg = (num < 0) != (den < 0);
    m = frac_quotient(mag64(num), mag64(den), neg ? 64'h8000_0000 : 64'h7FFF_FFFF);
    return neg ? -m : m;
  endfunction

  function automatic longint point_coord(longint base, longint r, longint delta);
    longint prod, m, v;
    prod = r * delta;
    m = mag64(prod) >>> (PARAM_FRAC_BITS - POINT_FRAC);
    v = base * 256 + (prod < 0 ? -m : m);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic bit on_unit(longint num, longint den);
    if (num == 0) return 1'b1;
    if ((num < 0) != (den < 0)) return 1'b0;
    return mag64(num) <= mag64(den);
  endfunction

  function automatic out_req_t predict_crossing(in_req_t r);
    out_req_t o;
    longint x1, y1, x2, y2, x3, y3, x4, y4;
    longint dx1, dy1, dx2, dy2, ex, ey, den, n1, n2, p1, p2;
    o = '0;
    x1 = r.seg1_start_x; y1 = r.seg1_start_y;
    x2 = r.seg1_end_x;   y2 = r.seg1_end_y;
    x3 = r.seg2_start_x; y3 = r.seg2_start_y;
    x4 = r.seg2_end_x;   y4 = r.seg2_end_y;
    dx1 = x2 - x1; dy1 = y2 - y1; dx2 = x4 - x3; dy2 = y4 - y3;
    ex = x1 - x3; ey = y1 - y3;
    den = dx1 * dy2 - dy1 * dx2;
    n1 = ey * dx2 - ex * dy2;
    n2 = ey * dx1 - ex * dy1;
    if (mag64(den) <= longint'(tolerance)) begin
      o.is_parallel = 1'b1;
      o.is_collinear = mag64(n1) <= longint'(tolerance);
    end else begin
      p1 = seg_param(n1, den);
      p2 = seg_param(n2, den);
      o.lines_cross = 1'b1;
      o.seg1_param = p1[31:0];
      o.seg2_param = p2[31:0];
      o.cross_x = 32'(point_coord(x1, p1, dx1));
      o.cross_y = 32'(point_coord(y1, p1, dy1));
      o.within_seg1 = on_unit(n1, den);
      o.within_seg2 = on_unit(n2, den);
      o.within_both = o.within_seg1 && o.within_seg2;
      o.accepted = (!r.require_on_seg1 || o.within_seg1) &&
                   (!r.require_on_seg2 || o.within_seg2);
    end
    return o;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    mismatch_count++;
  endtask

  // Driver: present the next request after a random gap; hold it until taken.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_crossing(in_data));
        send_gap = $urandom_range(0, 13);
        if (send_gap > 0 || pending_reqs.size() == 0 || hold_sender) begin
          in_valid <= 1'b0;
        end else begin
          in_data <= pending_reqs.pop_front();
        end
      end else if (!in_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0 && !hold_sender) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          send_gap = $urandom_range(0, 13);
          if ($urandom_range(0, 3) == 0) send_gap = 0;
        end
      end
    end
  end

  // Monitor: check each accepted result, then draw the next stall.
  int recv_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          automatic out_req_t e = expected_results.pop_front();
          if (out_data.is_parallel !== e.is_parallel)
            report_mismatch("is_parallel", out_data.is_parallel, e.is_parallel);
          if (out_data.is_collinear !== e.is_collinear)
            report_mismatch("is_collinear", out_data.is_collinear, e.is_collinear);
          if (out_data.lines_cross !== e.lines_cross)
            report_mismatch("lines_cross", out_data.lines_cross, e.lines_cross);
          if (out_data.within_seg1 !== e.within_seg1)
            report_mismatch("within_seg1", out_data.within_seg1, e.within_seg1);
          if (out_data.within_seg2 !== e.within_seg2)
            report_mismatch("within_seg2", out_data.within_seg2, e.within_seg2);
          if (out_data.within_both !== e.within_both)
            report_mismatch("within_both", out_data.within_both, e.within_both);
          if (out_data.accepted !== e.accepted)
            report_mismatch("accepted", out_data.accepted, e.accepted);
          if (out_data.cross_x !== e.cross_x)
            report_mismatch("cross_x", out_data.cross_x, e.cross_x);
          if (out_data.cross_y !== e.cross_y)
            report_mismatch("cross_y", out_data.cross_y, e.cross_y);
          if (out_data.seg1_param !== e.seg1_param)
            report_mismatch("seg1_param", out_data.seg1_param, e.seg1_param);
          if (out_data.seg2_param !== e.seg2_param)
            report_mismatch("seg2_param", out_data.seg2_param, e.seg2_param);
        end
        recv_gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
        if (recv_gap > 0) out_ready <= 1'b0;
      end else if (!out_ready) begin
        if (recv_gap > 0) recv_gap--;
        else out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("segment_intersection_top test failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 200)) - 100);
      default: return $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
    endcase
  endfunction

  function automatic in_req_t rand_segments();
    in_req_t r;
    int mode;
    mode = $urandom_range(0, 9);
    r.seg1_start_x = rand_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
    r.seg1_start_y = rand_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
    r.seg1_end_x   = rand_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
    r.seg1_end_y   = rand_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
    r.seg2_start_x = rand_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
    r.seg2_start_y = rand_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
    if (mode == 8) begin
      // Parallel to the first segment, often on the same line.
      r.seg2_end_x = r.seg2_start_x + (r.seg1_end_x - r.seg1_start_x);
      r.seg2_end_y = r.seg2_start_y + (r.seg1_end_y - r.seg1_start_y);
      if ($urandom_range(0, 1)) begin
        r.seg2_start_x = r.seg1_start_x;
        r.seg2_start_y = r.seg1_start_y;
        r.seg2_end_x = r.seg1_end_x;
        r.seg2_end_y = r.seg1_end_y;
      end
    end else begin
      r.seg2_end_x = rand_coord(mode < 5 ? 0 : 1);
      r.seg2_end_y = rand_coord(mode < 5 ? 0 : 1);
    end
    r.require_on_seg1 = $urandom_range(0, 1);
    r.require_on_seg2 = $urandom_range(0, 1);
    return r;
  endfunction

  function automatic in_req_t make_req(int a, int b, int c, int d, int e, int f,
                                        int g, int h, bit q1, bit q2);
    in_req_t r;
    r = '{16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g), 16'(h), q1, q2};
    return r;
  endfunction

  // Wait until the pipeline has drained, plus its latency.
  task automatic drain_pipeline();
    wait (pending_reqs.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_BITS-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tolerance = value;
  endtask

  initial begin
    logic [TOL_BITS-1:0] tol_steps[4];
    tol_steps = '{16'd0, 16'd1, 16'd500, 16'hFFFF};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: crossing, on and off segment, parallel, collinear, extremes.
    pending_reqs.push_back(make_req(0, 0, 10, 10, 0, 10, 10, 0, 1, 1));
    pending_reqs.push_back(make_req(0, 0, 1, 1, 5, 0, 5, 1, 1, 0));
    pending_reqs.push_back(make_req(0, 0, 1, 1, 5, 0, 5, 1, 0, 1));
    pending_reqs.push_back(make_req(0, 0, 1, 1, 5, 0, 5, 1, 0, 0));
    pending_reqs.push_back(make_req(0, 0, 4, 0, 0, 1, 4, 1, 0, 0));
    pending_reqs.push_back(make_req(0, 0, 4, 0, 6, 0, 9, 0, 1, 1));
    pending_reqs.push_back(make_req(0, 0, 4, 4, 4, 4, 8, 0, 1, 1));
    pending_reqs.push_back(make_req(-32768, -32768, 32767, 32767,
                                    -32768, 32767, 32767, -32768, 1, 1));
    pending_reqs.push_back(make_req(-32768, 0, 32767, 1, 0, -32768, 1, 32767, 0, 0));
    pending_reqs.push_back(make_req(32767, 32767, 32767, 32767, 0, 0, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(0, 0, 1, 0, -32768, -32768, 32767, -32767, 1, 0));
    pending_reqs.push_back(make_req(-32768, -32768, -32767, -32768,
                                    32767, 32767, 32767, -32768, 0, 0));
    drain_pipeline();

    foreach (tol_steps[t]) begin
      write_tolerance(tol_steps[t]);
      for (int i = 0; i < 200; i++) pending_reqs.push_back(rand_segments());
      if (t == 1) begin
        // Pause the sender mid-phase until every result has arrived.
        wait (pending_reqs.size() < 100);
        hold_sender = 1'b1;
        wait (expected_results.size() == 0 && !in_valid);
        hold_sender = 1'b0;
      end
      drain_pipeline();
    end
    write_tolerance(16'd0);

    if (mismatch_count == 0) begin
      $display("segment_intersection_top test passed");
    end else begin
      $display("segment_intersection_top test failed");
    end
    $finish;
  end
endmodule
